>>> rtl/core/boundary_tag_first_fit_allocator_unit_macros.svh
// ----------------------------------------------------------------------------
// Boundary tag allocator assertion macros
// Short forms for clocked assertions with reset disable.
// ----------------------------------------------------------------------------
`ifndef BOUNDARY_TAG_FIRST_FIT_ALLOCATOR_UNIT_MACROS_SVH
`define BOUNDARY_TAG_FIRST_FIT_ALLOCATOR_UNIT_MACROS_SVH

// Check a consequent in the same cycle as its antecedent
`define BTFFA_ASSERT_SAME(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("allocator check failed in the same cycle");

// Check a consequent in the cycle after its antecedent
`define BTFFA_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("allocator check failed one cycle later");

`endif

>>> rtl/core/btffa_pkg.sv
// ----------------------------------------------------------------------------
// Boundary tag allocator package
// Shared widths, tag and word types, codes and sequencer states.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package btffa_pkg;

  localparam int ARENA_UNITS = 4096;
  localparam int UNIT_SHIFT  = 4;
  localparam int UNIT_W      = 12;   // unit index
  localparam int SIZE_W      = 13;   // size in units, up to the arena size
  localparam int PTR_W       = 14;   // unit pointer that may run past the arena
  localparam int SUM_W       = 17;   // byte request plus header rounding

  // Request type codes
  localparam logic REQ_ALLOC   = 1'b0;
  localparam logic REQ_RELEASE = 1'b1;

  // Configuration register indexes
  localparam logic CFG_SPLIT_THR  = 1'b0;
  localparam logic CFG_GROW_EXTRA = 1'b1;

  // Result status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_OOM  = 2'd1;
  localparam logic [1:0] ST_NULL = 2'd2;

  typedef struct packed {
    logic [SIZE_W-1:0] size;
    logic [SIZE_W-1:0] prev;
    logic              used;
  } tag_t;

  typedef struct packed {
    logic        req_type;
    logic [15:0] alloc_size;
    logic [15:0] block_addr;
    logic        block_is_null;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] result_addr;
    logic [15:0] usable_size;
  } rsp_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_INIT0,
    S_INIT1,
    S_WALK0,
    S_WALK,
    S_GROW_RD,
    S_GROW_WR,
    S_GROW_END,
    S_SPLIT,
    S_SPLIT_TAIL,
    S_SPLIT_NRD,
    S_SPLIT_NWR,
    S_REL_RD,
    S_REL_CLR,
    S_REL_PREV,
    S_REL_NRD,
    S_REL_NXT,
    S_REL_NNX,
    S_REL_MRG,
    S_DONE
  } state_t;

endpackage

`default_nettype wire

>>> rtl/core/btffa_tag_ram.sv
// ----------------------------------------------------------------------------
// Boundary tag RAM
// One tag per arena unit, registered read; pointers past the arena read
// zero and drop writes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module btffa_tag_ram
  import btffa_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rd_en,
  input  wire logic [PTR_W-1:0] rd_addr,
  output tag_t                  rd_tag,
  input  wire logic             wr_en,
  input  wire logic [PTR_W-1:0] wr_addr,
  input  tag_t                  wr_tag
);

  tag_t tags [ARENA_UNITS];
  tag_t rd_data;
  logic rd_oob;

  // Write inside the arena only
  always_ff @(posedge clk) begin
    if (wr_en && (wr_addr[PTR_W-1:UNIT_W] == '0)) begin
      tags[wr_addr[UNIT_W-1:0]] <= wr_tag;
    end
  end

  // Registered read, remember whether it left the arena
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= tags[rd_addr[UNIT_W-1:0]];
      rd_oob  <= (rd_addr[PTR_W-1:UNIT_W] != '0);
    end
  end

  assign rd_tag = rd_oob ? '0 : rd_data;

endmodule

`default_nettype wire

>>> rtl/core/boundary_tag_first_fit_allocator_unit.sv
// ----------------------------------------------------------------------------
// Boundary tag first-fit allocator
// Heap allocator over a 4096-unit arena of 16-byte units, tags in one RAM.
// ----------------------------------------------------------------------------
//  channel  | handshake            | word
//  ---------+----------------------+--------------------------------------
//  req      | req_valid/req_stall  | req_type, alloc_size, block_addr, null
//  rsp      | rsp_valid/rsp_stall  | status, result_addr, usable_size
//  cfg      | cfg_valid/cfg_ready  | cfg_index, cfg_data
//
//  An allocate walks the chunks from the first-free hint, one tag RAM read
//  per chunk, then grows the heap if none fits and may split the chunk; the
//  first allocate creates the heap, and one that runs out of memory skips
//  the split. A release frees the chunk and merges it with free neighbors;
//  a null or ignored release and a first allocate too large for the arena
//  go straight to the result. One word is in work at a time; the result
//  register lets the next word in while it waits.
//  Reset needs no clearing pass: tags are written before they are read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module boundary_tag_first_fit_allocator_unit
  import btffa_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       req_valid,
  output logic            req_stall,
  input  req_t            req_word,
  output logic            rsp_valid,
  input  wire logic       rsp_stall,
  output rsp_t            rsp_word,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic       cfg_index,
  input  wire logic [15:0] cfg_data
);

  state_t state, state_next;

  logic [15:0]       split_thr;
  logic [15:0]       grow_extra;
  logic [UNIT_W-1:0] hint, hint_next;
  logic [SIZE_W-1:0] heap_end, heap_end_next;
  logic              heap_ready, heap_ready_next;

  logic              is_alloc, is_alloc_next;
  logic [1:0]        res_status, res_status_next;
  logic [SIZE_W-1:0] need, need_next;
  logic [SIZE_W-1:0] units, units_next;
  logic [PTR_W-1:0]  it, it_next;
  logic [UNIT_W-1:0] start, start_next;
  logic [UNIT_W-1:0] first, first_next;
  logic              seen, seen_next;
  logic [UNIT_W-1:0] found, found_next;
  logic [SIZE_W-1:0] total, total_next;
  logic [SIZE_W-1:0] fprev, fprev_next;
  logic [SIZE_W-1:0] rest, rest_next;
  logic [PTR_W-1:0]  ptr, ptr_next;
  logic [UNIT_W-1:0] rel_unit, rel_unit_next;
  logic [SIZE_W-1:0] cur_size, cur_size_next;
  logic [UNIT_W-1:0] m_unit, m_unit_next;
  logic [SIZE_W-1:0] m_size, m_size_next;
  logic [SIZE_W-1:0] m_prev, m_prev_next;

  logic             rd_en, wr_en;
  logic [PTR_W-1:0] rd_addr, wr_addr;
  tag_t             rd_tag, wr_tag;

  logic              accept;
  logic [SUM_W-1:0]  units_sum, need_sum;
  logic [SIZE_W-1:0] units_calc;
  logic              units_fit;
  logic              rel_bad;
  logic [UNIT_W-1:0] rel_calc;
  logic [PTR_W-1:0]  walk_step;
  logic              walk_end, walk_hit;
  logic [PTR_W-1:0]  grow_w;
  logic              grow_fit;
  logic [SIZE_W-1:0] rest_w;
  logic              split_ok;
  logic              prev_ok;
  logic              next_merge;
  logic              rsp_load;

  btffa_tag_ram u_ram (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_tag  (rd_tag),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_tag  (wr_tag)
  );

  assign accept    = req_valid && !req_stall;
  assign req_stall = (state != S_IDLE);
  assign cfg_ready = 1'b1;
  assign rsp_load  = (state == S_DONE) && (!rsp_valid || !rsp_stall);

  // Decode request sizes and release address checks
  assign units_sum  = {1'b0, req_word.alloc_size} + SUM_W'(3 * (1 << UNIT_SHIFT) - 1);
  assign need_sum   = {1'b0, req_word.alloc_size} + SUM_W'(2 * (1 << UNIT_SHIFT) - 1);
  assign units_calc = units_sum[SUM_W-1:UNIT_SHIFT];
  assign units_fit  = (units_calc <= SIZE_W'(ARENA_UNITS));
  assign rel_calc   = req_word.block_addr[15:UNIT_SHIFT] - UNIT_W'(1);
  assign rel_bad    = !heap_ready || (req_word.block_addr[UNIT_SHIFT-1:0] != '0)
                      || (req_word.block_addr[15:UNIT_SHIFT] == '0)
                      || ({1'b0, req_word.block_addr[15:UNIT_SHIFT]} >= heap_end);

  // Walk, growth and split decisions
  assign walk_step = it + {1'b0, rd_tag.size};
  assign walk_end  = (rd_tag.size == '0);
  assign walk_hit  = !walk_end && !rd_tag.used && (rd_tag.size >= need);
  assign grow_w    = {1'b0, need} + {2'b0, grow_extra[15:UNIT_SHIFT]};
  assign grow_fit  = (heap_end != '0) &&
                     (({2'b0, heap_end} + {1'b0, grow_w}) <= (PTR_W + 1)'(ARENA_UNITS));
  assign rest_w    = total - need;
  assign split_ok  = (total > need) && ({rest_w, 4'b0} >= {1'b0, split_thr});
  assign prev_ok   = (rd_tag.prev != '0) && (rd_tag.prev <= {1'b0, rel_unit});
  assign next_merge = !rd_tag.used && (rd_tag.size != '0);

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (req_word.req_type == REQ_ALLOC) begin
            if (heap_ready) begin
              state_next = S_WALK0;
            end else if (units_fit) begin
              state_next = S_INIT0;
            end else begin
              state_next = S_DONE;
            end
          end else if (req_word.block_is_null || rel_bad) begin
            state_next = S_DONE;
          end else begin
            state_next = S_REL_RD;
          end
        end
      end
      S_INIT0:      state_next = S_INIT1;
      S_INIT1:      state_next = S_WALK0;
      S_WALK0:      state_next = S_WALK;
      S_WALK: begin
        if (walk_hit) begin
          state_next = S_SPLIT;
        end else if (walk_end) begin
          state_next = grow_fit ? S_GROW_RD : S_DONE;
        end
      end
      S_GROW_RD:    state_next = S_GROW_WR;
      S_GROW_WR:    state_next = S_GROW_END;
      S_GROW_END:   state_next = S_SPLIT;
      S_SPLIT:      state_next = split_ok ? S_SPLIT_TAIL : S_DONE;
      S_SPLIT_TAIL: state_next = S_SPLIT_NRD;
      S_SPLIT_NRD:  state_next = S_SPLIT_NWR;
      S_SPLIT_NWR:  state_next = S_DONE;
      S_REL_RD:     state_next = S_REL_CLR;
      S_REL_CLR:    state_next = prev_ok ? S_REL_PREV : S_REL_NRD;
      S_REL_PREV:   state_next = S_REL_NRD;
      S_REL_NRD:    state_next = S_REL_NXT;
      S_REL_NXT:    state_next = next_merge ? S_REL_NNX : S_DONE;
      S_REL_NNX:    state_next = S_REL_MRG;
      S_REL_MRG:    state_next = S_DONE;
      S_DONE:       state_next = rsp_load ? S_IDLE : S_DONE;
      default:      state_next = S_IDLE;
    endcase
  end

  // Tag RAM accesses and working register updates
  always_comb begin
    rd_en           = 1'b0;
    rd_addr         = '0;
    wr_en           = 1'b0;
    wr_addr         = '0;
    wr_tag          = '0;
    hint_next       = hint;
    heap_end_next   = heap_end;
    heap_ready_next = heap_ready;
    is_alloc_next   = is_alloc;
    res_status_next = res_status;
    need_next       = need;
    units_next      = units;
    it_next         = it;
    start_next      = start;
    first_next      = first;
    seen_next       = seen;
    found_next      = found;
    total_next      = total;
    fprev_next      = fprev;
    rest_next       = rest;
    ptr_next        = ptr;
    rel_unit_next   = rel_unit;
    cur_size_next   = cur_size;
    m_unit_next     = m_unit;
    m_size_next     = m_size;
    m_prev_next     = m_prev;
    unique case (state)
      S_IDLE: begin
        // Latch the request and settle the trivial outcomes
        if (accept) begin
          is_alloc_next   = (req_word.req_type == REQ_ALLOC);
          need_next       = need_sum[SUM_W-1:UNIT_SHIFT];
          units_next      = units_calc;
          rel_unit_next   = rel_calc;
          res_status_next = ST_OK;
          if (req_word.req_type == REQ_ALLOC) begin
            if (!heap_ready && !units_fit) begin
              res_status_next = ST_OOM;
            end
          end else if (req_word.block_is_null) begin
            res_status_next = ST_NULL;
          end
        end
      end
      S_INIT0: begin
        // Create the heap: one free chunk at unit zero
        wr_en           = 1'b1;
        wr_addr         = '0;
        wr_tag          = '{size: units - SIZE_W'(1), prev: '0, used: 1'b0};
        heap_end_next   = units;
        hint_next       = '0;
        heap_ready_next = 1'b1;
      end
      S_INIT1: begin
        // Place the end tag
        wr_en   = 1'b1;
        wr_addr = PTR_W'(heap_end - SIZE_W'(1));
        wr_tag  = '{size: '0, prev: heap_end - SIZE_W'(1), used: 1'b0};
      end
      S_WALK0: begin
        // Start the walk at the first-free hint
        rd_en      = 1'b1;
        rd_addr    = {2'b0, hint};
        it_next    = {2'b0, hint};
        start_next = hint;
        seen_next  = 1'b0;
      end
      S_WALK: begin
        // Visit one chunk per cycle
        if (!walk_end && !rd_tag.used && !seen) begin
          seen_next  = 1'b1;
          first_next = it[UNIT_W-1:0];
        end
        if (walk_hit) begin
          wr_en      = 1'b1;
          wr_addr    = it;
          wr_tag     = '{size: rd_tag.size, prev: rd_tag.prev, used: 1'b1};
          found_next = it[UNIT_W-1:0];
          total_next = rd_tag.size;
          fprev_next = rd_tag.prev;
          hint_next  = seen ? first : it[UNIT_W-1:0];
        end else if (walk_end) begin
          hint_next = start;
          if (grow_fit) begin
            found_next = UNIT_W'(heap_end - SIZE_W'(1));
            total_next = grow_w[SIZE_W-1:0];
          end else begin
            res_status_next = ST_OOM;
          end
        end else begin
          rd_en   = 1'b1;
          rd_addr = walk_step;
          it_next = walk_step;
        end
      end
      S_GROW_RD: begin
        rd_en   = 1'b1;
        rd_addr = {2'b0, found};
      end
      S_GROW_WR: begin
        // Turn the end tag into a used chunk and move the heap end
        wr_en         = 1'b1;
        wr_addr       = {2'b0, found};
        wr_tag        = '{size: total, prev: rd_tag.prev, used: 1'b1};
        fprev_next    = rd_tag.prev;
        heap_end_next = heap_end + total;
      end
      S_GROW_END: begin
        wr_en   = 1'b1;
        wr_addr = PTR_W'(heap_end - SIZE_W'(1));
        wr_tag  = '{size: '0, prev: total, used: 1'b0};
      end
      S_SPLIT: begin
        // Trim the chunk to the request when the leftover is large enough
        if (split_ok) begin
          wr_en      = 1'b1;
          wr_addr    = {2'b0, found};
          wr_tag     = '{size: need, prev: fprev, used: 1'b1};
          rest_next  = rest_w;
          total_next = need;
          if (hint > found) begin
            hint_next = found;
          end
        end
      end
      S_SPLIT_TAIL: begin
        wr_en   = 1'b1;
        wr_addr = {2'b0, found} + {1'b0, need};
        wr_tag  = '{size: rest, prev: need, used: 1'b0};
      end
      S_SPLIT_NRD: begin
        rd_en    = 1'b1;
        rd_addr  = {2'b0, found} + {1'b0, need} + {1'b0, rest};
        ptr_next = {2'b0, found} + {1'b0, need} + {1'b0, rest};
      end
      S_SPLIT_NWR: begin
        wr_en   = 1'b1;
        wr_addr = ptr;
        wr_tag  = '{size: rd_tag.size, prev: rest, used: rd_tag.used};
      end
      S_REL_RD: begin
        rd_en   = 1'b1;
        rd_addr = {2'b0, rel_unit};
      end
      S_REL_CLR: begin
        // Free the chunk and look back at its neighbor
        wr_en         = 1'b1;
        wr_addr       = {2'b0, rel_unit};
        wr_tag        = '{size: rd_tag.size, prev: rd_tag.prev, used: 1'b0};
        cur_size_next = rd_tag.size;
        m_unit_next   = rel_unit;
        m_size_next   = rd_tag.size;
        m_prev_next   = rd_tag.prev;
        if (prev_ok) begin
          rd_en   = 1'b1;
          rd_addr = {2'b0, rel_unit - rd_tag.prev[UNIT_W-1:0]};
        end
      end
      S_REL_PREV: begin
        // Merge into a free previous chunk
        if (!rd_tag.used) begin
          wr_en       = 1'b1;
          wr_addr     = {2'b0, rel_unit - m_prev[UNIT_W-1:0]};
          wr_tag      = '{size: rd_tag.size + cur_size, prev: rd_tag.prev, used: 1'b0};
          m_unit_next = rel_unit - m_prev[UNIT_W-1:0];
          m_size_next = rd_tag.size + cur_size;
          m_prev_next = rd_tag.prev;
        end
      end
      S_REL_NRD: begin
        rd_en    = 1'b1;
        rd_addr  = {2'b0, rel_unit} + {1'b0, cur_size};
        ptr_next = {2'b0, rel_unit} + {1'b0, cur_size};
      end
      S_REL_NXT: begin
        // Relink the next chunk and absorb it if free
        wr_en   = 1'b1;
        wr_addr = ptr;
        wr_tag  = '{size: rd_tag.size, prev: m_size, used: rd_tag.used};
        if (next_merge) begin
          m_size_next = m_size + rd_tag.size;
          rd_en       = 1'b1;
          rd_addr     = ptr + {1'b0, rd_tag.size};
          ptr_next    = ptr + {1'b0, rd_tag.size};
        end else if (hint > m_unit) begin
          hint_next = m_unit;
        end
      end
      S_REL_NNX: begin
        wr_en   = 1'b1;
        wr_addr = ptr;
        wr_tag  = '{size: rd_tag.size, prev: m_size, used: rd_tag.used};
      end
      S_REL_MRG: begin
        wr_en   = 1'b1;
        wr_addr = {2'b0, m_unit};
        wr_tag  = '{size: m_size, prev: m_prev, used: 1'b0};
        if (hint > m_unit) begin
          hint_next = m_unit;
        end
      end
      S_DONE: begin
      end
      default: begin
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      hint       <= '0;
      heap_end   <= '0;
      heap_ready <= 1'b0;
      split_thr  <= 16'd256;
      grow_extra <= 16'd4096;
      rsp_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      hint       <= hint_next;
      heap_end   <= heap_end_next;
      heap_ready <= heap_ready_next;
      // Take configuration words at any time
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_SPLIT_THR:  split_thr  <= cfg_data;
          CFG_GROW_EXTRA: grow_extra <= cfg_data;
          default: begin
          end
        endcase
      end
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    is_alloc   <= is_alloc_next;
    res_status <= res_status_next;
    need       <= need_next;
    units      <= units_next;
    it         <= it_next;
    start      <= start_next;
    first      <= first_next;
    seen       <= seen_next;
    found      <= found_next;
    total      <= total_next;
    fprev      <= fprev_next;
    rest       <= rest_next;
    ptr        <= ptr_next;
    rel_unit   <= rel_unit_next;
    cur_size   <= cur_size_next;
    m_unit     <= m_unit_next;
    m_size     <= m_size_next;
    m_prev     <= m_prev_next;
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rsp_load) begin
      rsp_word.status <= res_status;
      if (is_alloc && (res_status == ST_OK)) begin
        rsp_word.result_addr <= {found + UNIT_W'(1), 4'b0};
        rsp_word.usable_size <= {total[UNIT_W-1:0] - UNIT_W'(1), 4'b0};
      end else begin
        rsp_word.result_addr <= '0;
        rsp_word.usable_size <= '0;
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/btffa_checker.sv
// ----------------------------------------------------------------------------
// Boundary tag allocator port checker
// Watches the request and result channels of the allocator top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "boundary_tag_first_fit_allocator_unit_macros.svh"

module btffa_checker
  import btffa_pkg::*;
(
  input wire logic clk,
  input wire logic rst,
  input wire logic req_valid,
  input wire logic req_stall,
  input wire logic rsp_valid,
  input wire logic rsp_stall,
  input rsp_t      rsp_word
);

  // Hold a stalled result word
  `BTFFA_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_word))

  // Block new words while one is in work
  `BTFFA_ASSERT_NEXT(a_busy_after_accept, req_valid && !req_stall, req_stall)

  // Report only defined status codes
  `BTFFA_ASSERT_SAME(a_status_code, rsp_valid,
                     rsp_word.status == ST_OK || rsp_word.status == ST_OOM ||
                     rsp_word.status == ST_NULL)

  // Drop address and size on failure
  `BTFFA_ASSERT_SAME(a_fail_zero, rsp_valid && rsp_word.status != ST_OK,
                     rsp_word.result_addr == '0 && rsp_word.usable_size == '0)

endmodule

bind boundary_tag_first_fit_allocator_unit btffa_checker u_btffa_checker (.*);

`default_nettype wire

>>> tb/tb_boundary_tag_first_fit_allocator_unit.sv
// ----------------------------------------------------------------------------
// Boundary tag allocator testbench
// Drives allocate and release words through the allocator and predicts each
// result with a behavioral heap of its own. Releases target only live blocks
// or addresses the block ignores, so no unwritten tag is ever read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_boundary_tag_first_fit_allocator_unit;
  import btffa_pkg::*;

  // --------------------------------------------------------------------------
  // Heap predictor and result checker
  // --------------------------------------------------------------------------
  class heap_scoreboard;
    int unsigned tag_size [ARENA_UNITS];
    int unsigned tag_prev [ARENA_UNITS];
    bit          tag_used [ARENA_UNITS];
    int unsigned end_unit;
    int unsigned hint;
    bit          ready;
    int unsigned split_thr;
    int unsigned grow_bytes;
    rsp_t        expected_q[$];
    logic [15:0] live_blocks[$];
    bit          failed;

    function new();
      end_unit = 0; hint = 0; ready = 0;
      split_thr = 256; grow_bytes = 4096; failed = 0;
    endfunction

    function int unsigned rd_size(int unsigned u);
      return (u < ARENA_UNITS) ? tag_size[u] : 0;
    endfunction
    function int unsigned rd_prev(int unsigned u);
      return (u < ARENA_UNITS) ? tag_prev[u] : 0;
    endfunction
    function bit rd_used(int unsigned u);
      return (u < ARENA_UNITS) ? tag_used[u] : 1'b0;
    endfunction
    function void wr_tag(int unsigned u, int unsigned sz, int unsigned pv, bit us);
      if (u < ARENA_UNITS) begin
        tag_size[u] = sz; tag_prev[u] = pv; tag_used[u] = us;
      end
    endfunction

    function void note_config(logic idx, logic [15:0] data);
      if (idx == CFG_SPLIT_THR) split_thr = data;
      else grow_bytes = data;
    endfunction

    // Carve the tail off a chunk when the leftover is large enough
    function void carve(int unsigned mem, int unsigned need);
      int unsigned total, rest;
      total = rd_size(mem);
      if (total <= need) return;
      rest = total - need;
      if (rest * 16 < split_thr) return;
      if (mem < ARENA_UNITS) tag_size[mem] = need;
      if (hint > mem) hint = mem;
      wr_tag(mem + need, rest, need, 1'b0);
      if (mem + need + rest < ARENA_UNITS) tag_prev[mem + need + rest] = rest;
    endfunction

    function rsp_t allocate(int unsigned req);
      rsp_t r;
      int unsigned need, it, start, found, first, sz, grow, units;
      bit hit, seen;
      r = '0;
      hit = 0; seen = 0; found = 0; first = 0;
      if (!ready) begin
        units = (req + 47) / 16;
        if (units > ARENA_UNITS || units < 2) begin
          r.status = ST_OOM;
          return r;
        end
        wr_tag(0, units - 1, 0, 1'b0);
        wr_tag(units - 1, 0, units - 1, 1'b0);
        end_unit = units; hint = 0; ready = 1;
      end
      need = (req + 31) / 16;
      start = hint;
      it = start;
      for (int steps = 0; steps < ARENA_UNITS; steps++) begin
        sz = rd_size(it);
        if (sz == 0) break;
        if (!rd_used(it)) begin
          if (!seen) begin
            seen = 1; first = it;
          end
          if (sz >= need) begin
            hit = 1; found = it;
            break;
          end
        end
        it += sz;
      end
      if (hit) begin
        hint = first;
        tag_used[found] = 1'b1;
        carve(found, need);
      end else begin
        grow = need + grow_bytes / 16;
        hint = start;
        if (end_unit == 0 || end_unit + grow > ARENA_UNITS) begin
          r.status = ST_OOM;
          return r;
        end
        found = end_unit - 1;
        tag_size[found] = grow;
        tag_used[found] = 1'b1;
        end_unit += grow;
        wr_tag(end_unit - 1, 0, grow, 1'b0);
        carve(found, need);
      end
      r.status = ST_OK;
      r.result_addr = 16'((found + 1) * 16);
      r.usable_size = 16'((rd_size(found) - 1) * 16);
      live_blocks.push_back(r.result_addr);
      return r;
    endfunction

    // Free a chunk and merge it with free neighbors
    function void release_block(int unsigned baddr);
      int unsigned mem, m, pv, nx, nsz;
      if (!ready || baddr % 16 != 0 || baddr < 16) return;
      mem = baddr / 16 - 1;
      if (mem + 1 >= end_unit) return;
      foreach (live_blocks[i])
        if (live_blocks[i] == baddr) begin
          live_blocks.delete(i);
          break;
        end
      if (mem < ARENA_UNITS) tag_used[mem] = 1'b0;
      m = mem;
      pv = rd_prev(mem);
      if (pv != 0 && pv <= mem && !rd_used(mem - pv)) begin
        tag_size[mem - pv] = rd_size(mem - pv) + rd_size(mem);
        m = mem - pv;
      end
      nx = mem + rd_size(mem);
      if (nx < ARENA_UNITS) tag_prev[nx] = rd_size(m);
      if (!rd_used(nx) && rd_size(nx) != 0) begin
        nsz = rd_size(nx);
        if (m < ARENA_UNITS) tag_size[m] = rd_size(m) + nsz;
        if (nx + nsz < ARENA_UNITS) tag_prev[nx + nsz] = rd_size(m);
      end
      if (hint > m) hint = m;
    endfunction

    function void note_request(req_t w);
      rsp_t r;
      r = '0;
      if (w.req_type == REQ_ALLOC) r = allocate(w.alloc_size);
      else if (w.block_is_null) r.status = ST_NULL;
      else release_block(w.block_addr);
      expected_q.push_back(r);
    endfunction

    function void check_result(rsp_t got);
      rsp_t exp_w;
      if (expected_q.size() == 0) begin
        $error("result word with nothing expected: %h", got);
        failed = 1;
        return;
      end
      exp_w = expected_q.pop_front();
      if (got.status !== exp_w.status) begin
        $error("status: expected %0d, got %0d", exp_w.status, got.status);
        failed = 1;
      end
      if (got.result_addr !== exp_w.result_addr) begin
        $error("result_addr: expected %0d, got %0d", exp_w.result_addr, got.result_addr);
        failed = 1;
      end
      if (got.usable_size !== exp_w.usable_size) begin
        $error("usable_size: expected %0d, got %0d", exp_w.usable_size, got.usable_size);
        failed = 1;
      end
    endfunction
  endclass

  localparam int WATCHDOG_LIMIT = 60000;

  logic clk, rst;
  logic req_valid, req_stall;
  req_t req_word;
  logic rsp_valid, rsp_stall;
  rsp_t rsp_word;
  logic cfg_valid, cfg_ready, cfg_index;
  logic [15:0] cfg_data;

  heap_scoreboard sb;
  bit  quiet;
  int  stall_left;
  int  idle_cycles;

  boundary_tag_first_fit_allocator_unit DUT (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall), .req_word(req_word),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_word(rsp_word),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Predict on every accepted word, check every accepted result
  always @(posedge clk) begin
    if (!rst) begin
      if (req_valid && !req_stall) sb.note_request(req_word);
      if (rsp_valid && !rsp_stall) sb.check_result(rsp_word);
      if (cfg_valid && cfg_ready) sb.note_config(cfg_index, cfg_data);
    end
  end

  // Hold the result side off for a random count after each result
  always @(posedge clk) begin
    if (rst) begin
      stall_left <= 0;
    end else if (rsp_valid && !rsp_stall) begin
      stall_left <= quiet ? 0 : $urandom_range(0, 9);
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end
  end
  always @(negedge clk) begin
    rsp_stall <= (stall_left > 0);
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_word(req_t w);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 9);
    repeat (gap) @(negedge clk);
    req_word = w;
    req_valid = 1'b1;
    do @(posedge clk); while (req_stall);
    @(negedge clk);
    req_valid = 1'b0;
  endtask

  task automatic write_reg(logic idx, logic [15:0] data);
    cfg_index = idx;
    cfg_data = data;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Let every expected result arrive, then let the block settle
  task automatic drain();
    while (sb.expected_q.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic alloc_word(logic [15:0] size);
    req_t w;
    w.req_type = REQ_ALLOC;
    w.alloc_size = size;
    w.block_addr = 16'($urandom);
    w.block_is_null = 1'($urandom);
    send_word(w);
  endtask

  task automatic release_word(logic [15:0] addr, logic is_null);
    req_t w;
    w.req_type = REQ_RELEASE;
    w.alloc_size = 16'($urandom);
    w.block_addr = addr;
    w.block_is_null = is_null;
    send_word(w);
  endtask

  task automatic release_live();
    int idx;
    idx = $urandom_range(0, sb.live_blocks.size() - 1);
    release_word(sb.live_blocks[idx], 1'b0);
  endtask

  // Bad address: misaligned, below one unit, or at or past the end tag
  function automatic logic [15:0] ignored_addr();
    logic [15:0] a;
    case ($urandom_range(0, 2))
      0: begin
        a = 16'($urandom);
        if (a[3:0] == 4'd0) a[3:0] = 4'($urandom_range(1, 15));
      end
      1: a = 16'd0;
      default: a = 16'(((sb.end_unit + $urandom_range(0, 100)) * 16) & 16'hFFF0);
    endcase
    if (a[3:0] == 4'd0 && a != 0 && a / 16 < sb.end_unit) a = 16'd0;
    return a;
  endfunction

  function automatic logic [15:0] pick_size();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 16'($urandom_range(0, 200));
    if (r < 95) return 16'($urandom_range(0, 2000));
    return 16'($urandom);
  endfunction

  task automatic random_item();
    int r;
    r = $urandom_range(0, 99);
    if (sb.live_blocks.size() > 30) r = (r < 50) ? 60 : r;
    if (r < 50) alloc_word(pick_size());
    else if (r < 88 && sb.live_blocks.size() != 0) release_live();
    else if (r < 94) release_word(16'($urandom), 1'b1);
    else release_word(ignored_addr(), 1'b0);
  endtask

  initial begin
    logic [15:0] thr_set[6] = '{16'd256, 16'd0, 16'd65535, 16'd16, 16'd48, 16'd0};
    logic [15:0] grow_set[6] = '{16'd4096, 16'd0, 16'd65535, 16'd17, 16'd512, 16'd0};
    sb = new();
    rst = 1'b1;
    req_valid = 1'b0; req_word = '0;
    cfg_valid = 1'b0; cfg_index = CFG_SPLIT_THR; cfg_data = '0;
    quiet = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: heap too big, releases before the heap, edge sizes
    release_word(16'h0010, 1'b0);
    alloc_word(16'hFFFF);
    alloc_word(16'd0);
    alloc_word(16'd1);
    alloc_word(16'd15);
    alloc_word(16'd16);
    alloc_word(16'd17);
    release_word(16'hFFFF, 1'b1);
    release_word(16'h0000, 1'b0);
    release_word(16'h0008, 1'b0);
    release_word(16'hFFF0, 1'b0);
    release_live();
    release_live();
    alloc_word(16'd5000);
    alloc_word(16'd40000);
    drain();
    write_reg(CFG_SPLIT_THR, 16'd0);
    write_reg(CFG_GROW_EXTRA, 16'd24);
    alloc_word(16'd100);
    release_live();
    alloc_word(16'd30);
    while (sb.live_blocks.size() != 0) release_live();
    drain();

    // Random phases over a spread of settings
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(CFG_SPLIT_THR, ph == 5 ? 16'($urandom) : thr_set[ph]);
      write_reg(CFG_GROW_EXTRA, ph == 5 ? 16'($urandom_range(0, 2048)) : grow_set[ph]);
      quiet = (ph == 3);
      for (int n = 0; n < 210; n++) random_item();
      while (sb.live_blocks.size() != 0) release_live();
      drain();
    end

    if (!sb.failed && sb.expected_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
